>>> rtl/rme_pkg.sv
package rme_pkg;

	localparam int FRAC_BITS_DEF    = 14;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int ELEM_W      = 16;
	localparam int OPND_W      = 17;
	localparam int ANG_W       = 34;
	localparam int OUT_W       = 16;
	localparam int GUARD_SHIFT = 16;
	localparam int OUT_SHIFT   = 17;
	localparam int OUT_HALF    = 65536;
	localparam int OUT_LIMIT   = 25736;
	localparam int ATAN_LEN    = 32;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_GIMBAL_LO,
		MODE_GIMBAL_HI
	} mode_t;

	// atan(2^-i) with 30 fraction bits
	localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
		34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
		34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
		34'sd1024,      34'sd512,       34'sd256,       34'sd128,
		34'sd64,        34'sd32,        34'sd16,        34'sd8,
		34'sd4,         34'sd2,         34'sd1,         34'sd0
	};

	// q30 angle to q3.13, round half up, saturate near +-pi
	function automatic logic signed [OUT_W-1:0] round_angle(input logic signed [ANG_W-1:0] z);
		logic signed [ANG_W:0]           sum;
		logic signed [ANG_W-OUT_SHIFT:0] q;
		sum = (ANG_W+1)'(z) + (ANG_W+1)'(OUT_HALF);
		q   = (ANG_W-OUT_SHIFT+1)'(sum >>> OUT_SHIFT);
		if (q > (ANG_W-OUT_SHIFT+1)'(OUT_LIMIT)) begin
			return OUT_W'(OUT_LIMIT);
		end else if (q < -(ANG_W-OUT_SHIFT+1)'(OUT_LIMIT)) begin
			return -OUT_W'(OUT_LIMIT);
		end
		return OUT_W'(q);
	endfunction

	localparam logic signed [OUT_W-1:0] HALF_PI_OUT = round_angle(HALF_PI_Q30);

endpackage

>>> rtl/rotation_matrix_to_euler_xyz.sv
// path: a beat taken at a start edge passes the front stage, the queue, the bit-per-stage
//   square root and the one-step-per-stage cordic pipelines, then the output register, and
//   comes back on done
// throughput: one beat per cycle, the receiver cannot stall so busy stays low
// reset: arst_n clears the front stage, the queue and the result strobe; no memory to clear
module rotation_matrix_to_euler_xyz #(
	parameter int FRAC_BITS    = rme_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [rme_pkg::ELEM_W-1:0] r00,
	input  logic signed [rme_pkg::ELEM_W-1:0] r01,
	input  logic signed [rme_pkg::ELEM_W-1:0] r02,
	input  logic signed [rme_pkg::ELEM_W-1:0] r10,
	input  logic signed [rme_pkg::ELEM_W-1:0] r20,
	input  logic signed [rme_pkg::ELEM_W-1:0] r21,
	input  logic signed [rme_pkg::ELEM_W-1:0] r22,
	output logic                              done,
	output logic signed [rme_pkg::OUT_W-1:0]  angle_x,
	output logic signed [rme_pkg::OUT_W-1:0]  angle_y,
	output logic signed [rme_pkg::OUT_W-1:0]  angle_z,
	output logic                              gimbal_lock
);
	import rme_pkg::*;

	localparam int RAD_W   = 2 * FRAC_BITS + 1;
	localparam int MODE_W  = $bits(mode_t);
	localparam int ITEM_W  = MODE_W + 5 * OPND_W + RAD_W;
	// edges from the accepting edge to the edge that takes the result
	localparam int LATENCY = FRAC_BITS + CORDIC_STEPS + 5;

	// front side: clamp r20, pick the branch and its atan2 operands, square r20
	logic                     f_valid, f_ready;
	mode_t                    f_mode;
	logic signed [OPND_W-1:0] f_ax_y, f_ax_x, f_az_y, f_az_x, f_ay_y;
	logic [RAD_W-1:0]         f_rad;

	// queue output toward the back side
	logic                     q_valid;
	logic [ITEM_W-1:0]        q_dout;
	mode_t                    b_mode;
	logic signed [OPND_W-1:0] b_ax_y, b_ax_x, b_az_y, b_az_x, b_ay_y;
	logic [RAD_W-1:0]         b_rad;

	logic                     accept_w;

	rme_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.r00        (r00),
		.r01        (r01),
		.r02        (r02),
		.r10        (r10),
		.r20        (r20),
		.r21        (r21),
		.r22        (r22),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.mode       (f_mode),
		.ax_y       (f_ax_y),
		.ax_x       (f_ax_x),
		.az_y       (f_az_y),
		.az_x       (f_az_x),
		.ay_y       (f_ay_y),
		.rad        (f_rad)
	);

	// two-entry queue decouples the classifier from the arithmetic pipeline
	rme_queue #(.DATA_W(ITEM_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.din        ({f_mode, f_ax_y, f_ax_x, f_az_y, f_az_x, f_ay_y, f_rad}),
		.pop_valid  (q_valid),
		.dout       (q_dout)
	);

	assign b_mode = mode_t'(q_dout[ITEM_W-1 -: MODE_W]);
	assign {b_ax_y, b_ax_x, b_az_y, b_az_x, b_ay_y, b_rad} = q_dout[ITEM_W-MODE_W-1:0];

	// back side: square root for asin, three cordic pipelines, rounding
	rme_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.mode        (b_mode),
		.ax_y        (b_ax_y),
		.ax_x        (b_ax_x),
		.az_y        (b_az_y),
		.az_x        (b_az_x),
		.ay_y        (b_ay_y),
		.rad         (b_rad),
		.done        (done),
		.angle_x     (angle_x),
		.angle_y     (angle_y),
		.angle_z     (angle_z),
		.gimbal_lock (gimbal_lock)
	);

	assign accept_w = start & ~busy & arst_n;

	// every accepted beat returns after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept_w |-> ##LATENCY done)
		else $error("result beat missing");

	// no result beat without a matching accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept_w, LATENCY))
		else $error("result beat without input");

	// gimbal branch forces z to zero and y to plus or minus pi/2
	a_gimbal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && gimbal_lock) |->
			(angle_z == '0) && (angle_y == HALF_PI_OUT || angle_y == -HALF_PI_OUT))
		else $error("gimbal angles wrong");

	// the pipeline drains a beat every cycle, so the queue never fills
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled up");

endmodule

>>> rtl/rme_front.sv
module rme_front #(
	parameter int FRAC_BITS = rme_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r00,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r01,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r02,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r10,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r20,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r21,
	input  logic signed [rme_pkg::ELEM_W-1:0]     r22,
	output logic                                  item_valid,
	input  logic                                  item_ready,
	output rme_pkg::mode_t                        mode,
	output logic signed [rme_pkg::OPND_W-1:0]     ax_y,
	output logic signed [rme_pkg::OPND_W-1:0]     ax_x,
	output logic signed [rme_pkg::OPND_W-1:0]     az_y,
	output logic signed [rme_pkg::OPND_W-1:0]     az_x,
	output logic signed [rme_pkg::OPND_W-1:0]     ay_y,
	output logic        [2*FRAC_BITS:0]           rad
);
	import rme_pkg::*;

	localparam int OP_W   = (OPND_W > FRAC_BITS + 2) ? OPND_W : FRAC_BITS + 2;
	localparam int CALC_W = (2 * OPND_W > 2 * FRAC_BITS + 2) ? 2 * OPND_W : 2 * FRAC_BITS + 2;
	localparam int RAD_W  = 2 * FRAC_BITS + 1;

	localparam logic signed [OP_W-1:0] ONE_W     = OP_W'(1) <<< FRAC_BITS;
	localparam logic signed [OP_W-1:0] NEG_ONE_W = -ONE_W;
	localparam logic [CALC_W-1:0]      ONE_SQ    = CALC_W'(1) << (2 * FRAC_BITS);

	logic                        valid_s1;
	mode_t                       mode_s1;
	logic signed [OPND_W-1:0]    ax_y_s1, ax_x_s1, az_y_s1, az_x_s1, ay_y_s1;
	logic [RAD_W-1:0]            rad_s1;

	logic                        accept;
	logic signed [OP_W-1:0]      r20_w, r20_cl;
	logic signed [OPND_W-1:0]    r20c, e01, e02;
	logic signed [2*OPND_W-1:0]  sq;
	logic [CALC_W-1:0]           rad_full;
	mode_t                       mode_c;
	logic signed [OPND_W-1:0]    ax_y_c, ax_x_c, az_y_c, az_x_c;

	assign busy   = valid_s1 & ~item_ready;
	assign accept = start & ~busy;

	always_comb begin
		r20_w = OP_W'(r20);
		if (r20_w > ONE_W) begin
			r20_cl = ONE_W;
		end else if (r20_w < NEG_ONE_W) begin
			r20_cl = NEG_ONE_W;
		end else begin
			r20_cl = r20_w;
		end
		if (r20_cl == NEG_ONE_W) begin
			mode_c = MODE_GIMBAL_LO;
		end else if (r20_cl == ONE_W) begin
			mode_c = MODE_GIMBAL_HI;
		end else begin
			mode_c = MODE_NORMAL;
		end
		r20c     = OPND_W'(r20_cl);
		sq       = r20c * r20c;
		rad_full = ONE_SQ - CALC_W'($unsigned(sq));
		e01      = OPND_W'(r01);
		e02      = OPND_W'(r02);
		case (mode_c)
			MODE_NORMAL: begin
				ax_y_c = OPND_W'(r21);
				ax_x_c = OPND_W'(r22);
				az_y_c = OPND_W'(r10);
				az_x_c = OPND_W'(r00);
			end
			MODE_GIMBAL_LO: begin
				ax_y_c = e01;
				ax_x_c = e02;
				az_y_c = '0;
				az_x_c = '0;
			end
			MODE_GIMBAL_HI: begin
				ax_y_c = -e01;
				ax_x_c = -e02;
				az_y_c = '0;
				az_x_c = '0;
			end
			default: begin
				ax_y_c = '0;
				ax_x_c = '0;
				az_y_c = '0;
				az_x_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~item_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_c;
			ax_y_s1 <= ax_y_c;
			ax_x_s1 <= ax_x_c;
			az_y_s1 <= az_y_c;
			az_x_s1 <= az_x_c;
			ay_y_s1 <= r20c;
			rad_s1  <= rad_full[RAD_W-1:0];
		end
	end

	assign item_valid = valid_s1;
	assign mode       = mode_s1;
	assign ax_y       = ax_y_s1;
	assign ax_x       = ax_x_s1;
	assign az_y       = az_y_s1;
	assign az_x       = az_x_s1;
	assign ay_y       = ay_y_s1;
	assign rad        = rad_s1;

endmodule

>>> rtl/rme_queue.sv
module rme_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] din,
	output logic              pop_valid,
	output logic [DATA_W-1:0] dout
);
	localparam int DEPTH = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic              wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;

	// back end never stalls, so every available beat pops
	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid & push_ready;
	assign dout       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop_valid);
		end
	end

endmodule

>>> rtl/rme_isqrt.sv
module rme_isqrt #(
	parameter int FRAC_BITS = rme_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic [2*FRAC_BITS:0] rad,
	output logic [FRAC_BITS:0]   root
);
	localparam int RAD_W  = 2 * FRAC_BITS + 1;
	localparam int ROOT_W = FRAC_BITS + 1;

	logic [RAD_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];

	// one root bit per stage, msb first
	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = FRAC_BITS - k;
		logic [RAD_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic [RAD_W+1:0]  trial;
		if (k == 0) begin : g_first
			assign cur_rem  = rad;
			assign cur_root = '0;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
		end
		assign trial = ((RAD_W+2)'(cur_root) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if ({2'b00, cur_rem} >= trial) begin
				rem_s[k+1]  <= cur_rem - trial[RAD_W-1:0];
				root_s[k+1] <= cur_root | (ROOT_W'(1) << B);
			end else begin
				rem_s[k+1]  <= cur_rem;
				root_s[k+1] <= cur_root;
			end
		end
	end

	assign root = root_s[ROOT_W];

endmodule

>>> rtl/rme_cordic.sv
module rme_cordic #(
	parameter int OP_W  = rme_pkg::OPND_W,
	parameter int STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic signed [OP_W-1:0]           y,
	input  logic signed [OP_W-1:0]           x,
	output logic signed [rme_pkg::ANG_W-1:0] z
);
	import rme_pkg::*;

	localparam int CW = OP_W + GUARD_SHIFT + 3;

	logic signed [CW-1:0]    x_s    [0:STEPS];
	logic signed [CW-1:0]    y_s    [0:STEPS];
	logic signed [ANG_W-1:0] z_s    [0:STEPS];
	logic                    zero_s [0:STEPS];

	logic signed [CW-1:0] xe, ye;

	assign xe = CW'(x) <<< GUARD_SHIFT;
	assign ye = CW'(y) <<< GUARD_SHIFT;

	// fold the left half plane onto the right
	always_ff @(posedge clk) begin
		zero_s[0] <= (x == '0) && (y == '0);
		if (xe < 0) begin
			if (ye >= 0) begin
				x_s[0] <= ye;
				y_s[0] <= -xe;
				z_s[0] <= HALF_PI_Q30;
			end else begin
				x_s[0] <= -ye;
				y_s[0] <= xe;
				z_s[0] <= -HALF_PI_Q30;
			end
		end else begin
			x_s[0] <= xe;
			y_s[0] <= ye;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (!y_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + ATAN_TAB[i];
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - ATAN_TAB[i];
			end
		end
	end

	// atan2(0, 0) is zero
	assign z = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule

>>> rtl/rme_back.sv
module rme_back #(
	parameter int FRAC_BITS    = rme_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  rme_pkg::mode_t                    mode,
	input  logic signed [rme_pkg::OPND_W-1:0] ax_y,
	input  logic signed [rme_pkg::OPND_W-1:0] ax_x,
	input  logic signed [rme_pkg::OPND_W-1:0] az_y,
	input  logic signed [rme_pkg::OPND_W-1:0] az_x,
	input  logic signed [rme_pkg::OPND_W-1:0] ay_y,
	input  logic        [2*FRAC_BITS:0]       rad,
	output logic                              done,
	output logic signed [rme_pkg::OUT_W-1:0]  angle_x,
	output logic signed [rme_pkg::OUT_W-1:0]  angle_y,
	output logic signed [rme_pkg::OUT_W-1:0]  angle_z,
	output logic                              gimbal_lock
);
	import rme_pkg::*;

	localparam int OP_W  = (OPND_W > FRAC_BITS + 2) ? OPND_W : FRAC_BITS + 2;
	localparam int SQ_L  = FRAC_BITS + 1;
	localparam int TOT_L = SQ_L + CORDIC_STEPS + 1;
	localparam int PK_W  = 5 * OPND_W;

	logic [PK_W-1:0]     opnd_d  [1:SQ_L];
	logic                valid_d [1:TOT_L];
	mode_t               mode_d  [1:TOT_L];

	logic [FRAC_BITS:0]       root;
	logic signed [OPND_W-1:0] ax_y_d, ax_x_d, az_y_d, az_x_d, ay_y_d;
	logic signed [ANG_W-1:0]  zx, zy, zz, zy_sel;

	logic                     done_q, gimbal_q;
	logic signed [OUT_W-1:0]  ax_q, ay_q, az_q;

	rme_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
		.clk  (clk),
		.rad  (rad),
		.root (root)
	);

	// operands wait out the square root
	always_ff @(posedge clk) begin
		opnd_d[1] <= {ax_y, ax_x, az_y, az_x, ay_y};
		for (int k = 2; k <= SQ_L; k++) begin
			opnd_d[k] <= opnd_d[k-1];
		end
		mode_d[1] <= mode;
		for (int k = 2; k <= TOT_L; k++) begin
			mode_d[k] <= mode_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= TOT_L; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else begin
			valid_d[1] <= in_valid;
			for (int k = 2; k <= TOT_L; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	assign {ax_y_d, ax_x_d, az_y_d, az_x_d, ay_y_d} = opnd_d[SQ_L];

	rme_cordic #(.OP_W(OP_W), .STEPS(CORDIC_STEPS)) u_cordic_x (
		.clk (clk),
		.y   (OP_W'(ax_y_d)),
		.x   (OP_W'(ax_x_d)),
		.z   (zx)
	);

	rme_cordic #(.OP_W(OP_W), .STEPS(CORDIC_STEPS)) u_cordic_y (
		.clk (clk),
		.y   (OP_W'(ay_y_d)),
		.x   ($signed(OP_W'(root))),
		.z   (zy)
	);

	rme_cordic #(.OP_W(OP_W), .STEPS(CORDIC_STEPS)) u_cordic_z (
		.clk (clk),
		.y   (OP_W'(az_y_d)),
		.x   (OP_W'(az_x_d)),
		.z   (zz)
	);

	always_comb begin
		case (mode_d[TOT_L])
			MODE_NORMAL:    zy_sel = -zy;
			MODE_GIMBAL_LO: zy_sel = HALF_PI_Q30;
			MODE_GIMBAL_HI: zy_sel = -HALF_PI_Q30;
			default:        zy_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_d[TOT_L];
		end
	end

	always_ff @(posedge clk) begin
		ax_q     <= round_angle(zx);
		ay_q     <= round_angle(zy_sel);
		az_q     <= round_angle(zz);
		gimbal_q <= (mode_d[TOT_L] != MODE_NORMAL);
	end

	assign done        = done_q;
	assign angle_x     = ax_q;
	assign angle_y     = ay_q;
	assign angle_z     = az_q;
	assign gimbal_lock = gimbal_q;

endmodule
